// ===== design/scsd_pkg.sv =====
// ----------------------------------------------------------------------------
// scsd_pkg
// Shared types and constants for the step counter and sleep detector:
// beat payloads, configuration set, controller states and datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

package scsd_pkg;

  // fixed-point one g in q4.12
  localparam logic [15:0] ONE_G = 16'd4096;

  // saturation limits
  localparam logic [23:0] STEP_MAX     = 24'hFF_FFFF;
  localparam logic [7:0]  ACTIVITY_MAX = 8'hFF;

  // square root iterations, one result bit each
  localparam int unsigned ROOT_STEPS = 16;
  localparam int unsigned ROOT_CNT_W = $clog2(ROOT_STEPS);

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MAGNITUDE_MIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAGNITUDE_MAX      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_INTERVAL_MS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLEEP_TIMEOUT_MS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVITY_WINDOW_MS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WAKE_STEP_COUNT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VARIANCE_LIMIT     = 3'd6;

  // register reset values
  localparam logic [15:0] RST_MAGNITUDE_MIN      = 16'd5325;
  localparam logic [15:0] RST_MAGNITUDE_MAX      = 16'd12288;
  localparam logic [15:0] RST_STEP_INTERVAL_MS   = 16'd300;
  localparam logic [31:0] RST_SLEEP_TIMEOUT_MS   = 32'd300000;
  localparam logic [31:0] RST_ACTIVITY_WINDOW_MS = 32'd20000;
  localparam logic [7:0]  RST_WAKE_STEP_COUNT    = 8'd15;
  localparam logic [31:0] RST_VARIANCE_LIMIT     = 32'd838861;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [31:0]        timestamp_ms;
    logic               day_rollover;
  } in_item_t;

  typedef struct packed {
    logic [23:0] step_total;
    logic        step_seen;
    logic        asleep;
    logic [15:0] magnitude;
  } out_item_t;

  typedef struct packed {
    logic [15:0] magnitude_min;
    logic [15:0] magnitude_max;
    logic [15:0] step_interval_ms;
    logic [31:0] sleep_timeout_ms;
    logic [31:0] activity_window_ms;
    logic [7:0]  wake_step_count;
    logic [31:0] variance_limit;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SQZ,
    ST_SQACC,
    ST_RINIT,
    ST_ROOT,
    ST_OLDSQ,
    ST_MAGSQ,
    ST_SQADD,
    ST_VMUL,
    ST_VCMP,
    ST_FIN
  } state_t;

  // operand select of the shared squaring multiplier
  typedef enum logic [2:0] {
    MUL_X,
    MUL_Y,
    MUL_Z,
    MUL_OLD,
    MUL_MAG
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_load;
    logic     acc_add;
    logic     ring_rd;
    logic     root_init;
    logic     root_step;
    logic     ring_upd;
    logic     sq_add;
    logic     var_mul;
    logic     var_cmp;
    logic     finish;
  } cmd_t;

endpackage

`default_nettype wire

// ===== design/scsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// scsd_ctrl
// Sequencer for one sample: squares, square root, ring update, variance
// test and result hand-off. Also owns the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module scsd_ctrl
  import scsd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  output cmd_t      cmd
);

  state_t                state_r, state_nxt;
  logic [ROOT_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_free;

  // output slot can take a new beat this cycle
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // state and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.mul_sel   = MUL_X;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SQX;
        end
      end
      ST_SQX: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_X;
        state_nxt   = ST_SQY;
      end
      ST_SQY: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_Y;
        cmd.acc_load = 1'b1;
        state_nxt    = ST_SQZ;
      end
      ST_SQZ: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_Z;
        cmd.acc_add = 1'b1;
        state_nxt   = ST_SQACC;
      end
      ST_SQACC: begin
        cmd.acc_add = 1'b1;
        cmd.ring_rd = 1'b1;
        state_nxt   = ST_RINIT;
      end
      ST_RINIT: begin
        cmd.root_init = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == ROOT_CNT_W'(ROOT_STEPS - 1)) state_nxt = ST_OLDSQ;
      end
      ST_OLDSQ: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_OLD;
        state_nxt   = ST_MAGSQ;
      end
      ST_MAGSQ: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_MAG;
        cmd.ring_upd = 1'b1;
        state_nxt    = ST_SQADD;
      end
      ST_SQADD: begin
        cmd.sq_add = 1'b1;
        state_nxt  = ST_VMUL;
      end
      ST_VMUL: begin
        cmd.var_mul = 1'b1;
        state_nxt   = ST_VCMP;
      end
      ST_VCMP: begin
        cmd.var_cmp = 1'b1;
        state_nxt   = ST_FIN;
      end
      ST_FIN: begin
        // wait here until the output slot is free
        if (out_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/scsd_dp.sv =====
// ----------------------------------------------------------------------------
// scsd_dp
// Datapath: shared squaring multiplier, bit-serial square root, magnitude
// ring with running sums, step test, variance test and sleep/wake state.
// ----------------------------------------------------------------------------
`default_nettype none

module scsd_dp
  import scsd_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = 20
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cmd_t     cmd,
  input  wire cfg_t     cfg,
  input  wire in_item_t in_item,
  output out_item_t     out_item
);

  localparam int unsigned PTR_W  = $clog2(WINDOW_LEN);
  localparam int unsigned SUM_W  = 16 + $clog2(WINDOW_LEN);
  localparam int unsigned SQ_W   = 32 + $clog2(WINDOW_LEN);
  localparam int unsigned CMP_W  = 33 + 2 * $clog2(WINDOW_LEN);
  localparam int unsigned WIN_SQ = WINDOW_LEN * WINDOW_LEN;

  // item and arithmetic registers
  in_item_t         item_r;
  logic [31:0]      prod_r, prod_nxt;
  logic [31:0]      acc_r, acc_nxt;
  logic [31:0]      rad_r, rad_nxt;
  logic [18:0]      rem_r, rem_nxt;
  logic [15:0]      root_r, root_nxt;
  logic [15:0]      rd_r;
  logic             rd_vld_r;
  logic [CMP_W-1:0] lhs_r, sumsq_r, lim_r;
  logic             quiet_r;
  out_item_t        out_item_r;

  // state registers
  logic [15:0]          ring_mem [WINDOW_LEN];
  logic [WINDOW_LEN-1:0] vld_r, vld_nxt;
  logic [PTR_W-1:0]     ptr_r, ptr_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [SQ_W-1:0]      sq_r, sq_nxt;
  logic [23:0]          step_cnt_r, step_cnt_nxt;
  logic [7:0]           act_cnt_r, act_cnt_nxt;
  logic [31:0]          last_step_r, last_step_nxt;
  logic [31:0]          last_act_r, last_act_nxt;
  logic                 sleep_r, sleep_nxt;
  logic                 seen_r, seen_nxt;

  // helpers
  logic [15:0] abs_x, abs_y, abs_z, old_mag, mul_op;
  logic [18:0] rem_try;
  logic [18:0] trial;
  logic        step_hit;
  logic [31:0] idle_ms;
  logic        sleep_f;
  logic [7:0]  act_f;
  logic [23:0] step_f;

  // magnitudes of the signed axes, -32768 maps to 0x8000
  assign abs_x   = item_r.accel_x[15] ? 16'(-item_r.accel_x) : item_r.accel_x;
  assign abs_y   = item_r.accel_y[15] ? 16'(-item_r.accel_y) : item_r.accel_y;
  assign abs_z   = item_r.accel_z[15] ? 16'(-item_r.accel_z) : item_r.accel_z;
  assign old_mag = rd_vld_r ? rd_r : ONE_G;

  // square root step: bring down two radicand bits, try subtracting 4r+1
  assign rem_try = {rem_r[16:0], rad_r[31:30]};
  assign trial   = {1'b0, root_r, 2'b01};

  // step test on the new magnitude
  assign step_hit = (root_r > cfg.magnitude_min) && (root_r < cfg.magnitude_max) &&
                    ((item_r.timestamp_ms - last_step_r) > {16'd0, cfg.step_interval_ms});

  // operand select of the squaring multiplier
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_X:   mul_op = abs_x;
      MUL_Y:   mul_op = abs_y;
      MUL_Z:   mul_op = abs_z;
      MUL_OLD: mul_op = old_mag;
      MUL_MAG: mul_op = root_r;
      default: mul_op = '0;
    endcase
  end

  // sleep, wake, activity window and rollover at the end of the item
  always_comb begin
    idle_ms = item_r.timestamp_ms - last_act_r;
    sleep_f = sleep_r;
    act_f   = act_cnt_r;
    if (((idle_ms > cfg.sleep_timeout_ms) || quiet_r) && !sleep_r) begin
      sleep_f = 1'b1;
      act_f   = '0;
    end
    if (sleep_f && (act_f >= cfg.wake_step_count)) sleep_f = 1'b0;
    if (idle_ms > cfg.activity_window_ms) act_f = '0;
    step_f = item_r.day_rollover ? '0 : step_cnt_r;
  end

  // next-value logic
  always_comb begin
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    rad_nxt       = rad_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    vld_nxt       = vld_r;
    ptr_nxt       = ptr_r;
    sum_nxt       = sum_r;
    sq_nxt        = sq_r;
    step_cnt_nxt  = step_cnt_r;
    act_cnt_nxt   = act_cnt_r;
    last_step_nxt = last_step_r;
    last_act_nxt  = last_act_r;
    sleep_nxt     = sleep_r;
    seen_nxt      = seen_r;

    if (cmd.mul_en)   prod_nxt = mul_op * mul_op;
    if (cmd.acc_load) acc_nxt  = prod_r;
    if (cmd.acc_add)  acc_nxt  = acc_r + prod_r;

    if (cmd.root_init) begin
      rad_nxt  = acc_r;
      rem_nxt  = '0;
      root_nxt = '0;
    end
    if (cmd.root_step) begin
      rad_nxt = {rad_r[29:0], 2'b00};
      if (rem_try >= trial) begin
        rem_nxt  = rem_try - trial;
        root_nxt = {root_r[14:0], 1'b1};
      end else begin
        rem_nxt  = rem_try;
        root_nxt = {root_r[14:0], 1'b0};
      end
    end

    // ring update: prod_r holds the outgoing square here
    if (cmd.ring_upd) begin
      sum_nxt        = sum_r - SUM_W'(old_mag) + SUM_W'(root_r);
      sq_nxt         = sq_r - SQ_W'(prod_r);
      vld_nxt[ptr_r] = 1'b1;
      ptr_nxt        = (ptr_r == PTR_W'(WINDOW_LEN - 1)) ? '0 : ptr_r + 1'b1;
      seen_nxt       = step_hit;
      if (step_hit) begin
        if (step_cnt_r != STEP_MAX) step_cnt_nxt = step_cnt_r + 1'b1;
        if (act_cnt_r != ACTIVITY_MAX) act_cnt_nxt = act_cnt_r + 1'b1;
        last_step_nxt = item_r.timestamp_ms;
        last_act_nxt  = item_r.timestamp_ms;
      end
    end
    if (cmd.sq_add) sq_nxt = sq_r + SQ_W'(prod_r);

    if (cmd.finish) begin
      sleep_nxt    = sleep_f;
      act_cnt_nxt  = act_f;
      step_cnt_nxt = step_f;
    end
  end

  // state registers with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      ptr_r       <= '0;
      sum_r       <= SUM_W'(WINDOW_LEN) << 12;
      sq_r        <= SQ_W'(WINDOW_LEN) << 24;
      step_cnt_r  <= '0;
      act_cnt_r   <= '0;
      last_step_r <= '0;
      last_act_r  <= '0;
      sleep_r     <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      ptr_r       <= ptr_nxt;
      sum_r       <= sum_nxt;
      sq_r        <= sq_nxt;
      step_cnt_r  <= step_cnt_nxt;
      act_cnt_r   <= act_cnt_nxt;
      last_step_r <= last_step_nxt;
      last_act_r  <= last_act_nxt;
      sleep_r     <= sleep_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    seen_r <= seen_nxt;
    if (cmd.load) item_r <= in_item;
    if (cmd.var_mul) begin
      lhs_r   <= CMP_W'(sq_r) * CMP_W'(WINDOW_LEN);
      sumsq_r <= CMP_W'(sum_r) * CMP_W'(sum_r);
      lim_r   <= CMP_W'(cfg.variance_limit) * CMP_W'(WIN_SQ);
    end
    if (cmd.var_cmp) quiet_r <= (lhs_r < (sumsq_r + lim_r));
    if (cmd.finish) begin
      out_item_r.step_total <= step_f;
      out_item_r.step_seen  <= seen_r;
      out_item_r.asleep     <= sleep_f;
      out_item_r.magnitude  <= root_r;
    end
  end

  // magnitude ring memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.ring_rd) begin
      rd_r     <= ring_mem[ptr_r];
      rd_vld_r <= vld_r[ptr_r];
    end
    if (cmd.ring_upd) ring_mem[ptr_r] <= root_r;
  end

  assign out_item = out_item_r;

endmodule

`default_nettype wire

// ===== design/step_counter_sleep_detector.sv =====
// ----------------------------------------------------------------------------
// step_counter_sleep_detector
// Accelerometer step counter and sleep detector.
//
// Input channel (in_valid / in_stall / in_item): one beat per sample with
// x, y, z in signed q4.12 g, a millisecond timestamp and a day rollover flag.
// Output channel (out_valid / out_stall / out_item): one beat per sample
// with the step total, step flag, sleep flag and magnitude.
// Configuration: cfg_wr_en / cfg_index / cfg_wdata, write only; the user must
// write it only while the block is idle, which the block does not enforce. An
// index beyond the register list is ignored.
// Processing: one sample at a time; a beat is taken only in the idle state,
// so no new beat is accepted until the last result has been passed to the
// output register. The bit-serial square root is the longest part of the work.
// Stalls: the result sits in an output register; while it is stalled the
// next sample is still accepted and computed, then waits before its result
// is handed over.
// Reset (rst_n low, synchronous): registers to defaults, ring reads as one g
// in every entry, counts and timestamps zero, awake. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module step_counter_sleep_detector
  import scsd_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = 20
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_item,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_item,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg_r, cfg_nxt;
  cmd_t cmd;

  // configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MAGNITUDE_MIN:      cfg_nxt.magnitude_min      = cfg_wdata[15:0];
        REG_MAGNITUDE_MAX:      cfg_nxt.magnitude_max      = cfg_wdata[15:0];
        REG_STEP_INTERVAL_MS:   cfg_nxt.step_interval_ms   = cfg_wdata[15:0];
        REG_SLEEP_TIMEOUT_MS:   cfg_nxt.sleep_timeout_ms   = cfg_wdata;
        REG_ACTIVITY_WINDOW_MS: cfg_nxt.activity_window_ms = cfg_wdata;
        REG_WAKE_STEP_COUNT:    cfg_nxt.wake_step_count    = cfg_wdata[7:0];
        REG_VARIANCE_LIMIT:     cfg_nxt.variance_limit     = cfg_wdata;
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.magnitude_min      <= RST_MAGNITUDE_MIN;
      cfg_r.magnitude_max      <= RST_MAGNITUDE_MAX;
      cfg_r.step_interval_ms   <= RST_STEP_INTERVAL_MS;
      cfg_r.sleep_timeout_ms   <= RST_SLEEP_TIMEOUT_MS;
      cfg_r.activity_window_ms <= RST_ACTIVITY_WINDOW_MS;
      cfg_r.wake_step_count    <= RST_WAKE_STEP_COUNT;
      cfg_r.variance_limit     <= RST_VARIANCE_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // sequencer
  scsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // arithmetic and state
  scsd_dp #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .cfg      (cfg_r),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

// ===== dv/step_counter_sleep_detector_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// step_counter_sleep_detector_checker
// Watches the sample, report and register ports of the step counter. Keeps
// its own copy of the magnitude window, counters and sleep flag, works out
// the report due for every accepted sample and compares it, field by field,
// with the reports that the block hands over.
// ----------------------------------------------------------------------------

module step_counter_sleep_detector_checker
  import scsd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_item,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_item,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    report_mismatches,
  output int                    reports_due
);

  localparam int              WINDOW  = 20;
  localparam longint unsigned WIN_LEN = 64'd20;

  // shadow of the register set and the detector state
  cfg_t              regs;
  logic [15:0]       mag_hist [WINDOW];
  int                hist_pos;
  longint unsigned   hist_sum;
  longint unsigned   hist_sq_sum;
  logic [23:0]       steps;
  logic [7:0]        active_steps;
  logic [31:0]       last_step_t;
  logic [31:0]       last_active_t;
  logic              sleeping;

  out_item_t         motion_reports [$];

  // bit by bit floor square root, 17 result bits cover three full squares
  function automatic logic [15:0] floor_root(input longint unsigned v);
    logic [16:0] r;
    r = '0;
    for (int b = 16; b >= 0; b--) begin
      longint unsigned rr;
      r[b] = 1'b1;
      rr = r;
      if (rr * rr > v) r[b] = 1'b0;
    end
    return r[15:0];
  endfunction

  // one sample through window, step, sleep, wake and rollover logic
  function automatic out_item_t track_motion(input in_item_t s);
    longint signed   ax, ay, az;
    longint unsigned power, old_mag, new_mag;
    logic [31:0]     now, since_step, since_active;
    logic [15:0]     mag;
    logic            seen, quiet;
    out_item_t       r;
    ax = $signed(s.accel_x);
    ay = $signed(s.accel_y);
    az = $signed(s.accel_z);
    power = ax * ax + ay * ay + az * az;
    mag = floor_root(power);

    // window update
    old_mag = mag_hist[hist_pos];
    new_mag = mag;
    hist_sum = hist_sum - old_mag + new_mag;
    hist_sq_sum = hist_sq_sum - old_mag * old_mag + new_mag * new_mag;
    mag_hist[hist_pos] = mag;
    hist_pos = (hist_pos == WINDOW - 1) ? 0 : hist_pos + 1;

    // step test, bounds exclusive, interval must be exceeded
    now = s.timestamp_ms;
    since_step = now - last_step_t;
    seen = 1'b0;
    if (mag > regs.magnitude_min && mag < regs.magnitude_max &&
        since_step > 32'(regs.step_interval_ms)) begin
      seen = 1'b1;
      if (steps != STEP_MAX) steps = steps + 24'd1;
      last_step_t = now;
      last_active_t = now;
      if (active_steps != ACTIVITY_MAX) active_steps = active_steps + 8'd1;
    end

    // sleep entry on inactivity or low window variance
    since_active = now - last_active_t;
    quiet = (WIN_LEN * hist_sq_sum) <
            (hist_sum * hist_sum + WIN_LEN * WIN_LEN * 64'(regs.variance_limit));
    if (since_active > regs.sleep_timeout_ms || quiet) begin
      if (!sleeping) begin
        sleeping = 1'b1;
        active_steps = '0;
      end
    end
    if (sleeping && active_steps >= regs.wake_step_count) sleeping = 1'b0;
    if (since_active > regs.activity_window_ms) active_steps = '0;
    if (s.day_rollover) steps = '0;

    r.step_total = steps;
    r.step_seen  = seen;
    r.asleep     = sleeping;
    r.magnitude  = mag;
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      regs.magnitude_min      = RST_MAGNITUDE_MIN;
      regs.magnitude_max      = RST_MAGNITUDE_MAX;
      regs.step_interval_ms   = RST_STEP_INTERVAL_MS;
      regs.sleep_timeout_ms   = RST_SLEEP_TIMEOUT_MS;
      regs.activity_window_ms = RST_ACTIVITY_WINDOW_MS;
      regs.wake_step_count    = RST_WAKE_STEP_COUNT;
      regs.variance_limit     = RST_VARIANCE_LIMIT;
      for (int i = 0; i < WINDOW; i++) mag_hist[i] = ONE_G;
      hist_pos      = 0;
      hist_sum      = WIN_LEN * ONE_G;
      hist_sq_sum   = WIN_LEN * ONE_G * ONE_G;
      steps         = '0;
      active_steps  = '0;
      last_step_t   = '0;
      last_active_t = '0;
      sleeping      = 1'b0;
      motion_reports.delete();
      report_mismatches = 0;
    end else begin
      // register writes, masked to the register width
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_MAGNITUDE_MIN:      regs.magnitude_min      = cfg_wdata[15:0];
          REG_MAGNITUDE_MAX:      regs.magnitude_max      = cfg_wdata[15:0];
          REG_STEP_INTERVAL_MS:   regs.step_interval_ms   = cfg_wdata[15:0];
          REG_SLEEP_TIMEOUT_MS:   regs.sleep_timeout_ms   = cfg_wdata;
          REG_ACTIVITY_WINDOW_MS: regs.activity_window_ms = cfg_wdata;
          REG_WAKE_STEP_COUNT:    regs.wake_step_count    = cfg_wdata[7:0];
          REG_VARIANCE_LIMIT:     regs.variance_limit     = cfg_wdata;
          default: ;
        endcase
      end

      // report beat against the oldest one due
      if (out_valid && !out_stall) begin
        if (motion_reports.size() == 0) begin
          report_mismatches++;
          $display("%0t unexpected report: expected none, got total=%0d step=%0b asleep=%0b mag=%0d",
                   $time, out_item.step_total, out_item.step_seen, out_item.asleep,
                   out_item.magnitude);
        end else begin
          want = motion_reports.pop_front();
          if (out_item.step_total !== want.step_total ||
              out_item.step_seen  !== want.step_seen  ||
              out_item.asleep     !== want.asleep     ||
              out_item.magnitude  !== want.magnitude) begin
            report_mismatches++;
            $display("%0t report mismatch: expected total=%0d step=%0b asleep=%0b mag=%0d, got total=%0d step=%0b asleep=%0b mag=%0d",
                     $time, want.step_total, want.step_seen, want.asleep, want.magnitude,
                     out_item.step_total, out_item.step_seen, out_item.asleep,
                     out_item.magnitude);
          end
        end
      end

      // sample beat
      if (in_valid && !in_stall) motion_reports.push_back(track_motion(in_item));
    end
    reports_due <= motion_reports.size();
  end

endmodule

// ===== dv/step_counter_sleep_detector_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// step_counter_sleep_detector_tb
// Drives accelerometer samples into the step counter through several
// register settings and idling patterns, including a long report hold that
// backs the block up, and gives the verdict from the checker's count.
// ----------------------------------------------------------------------------

module step_counter_sleep_detector_tb;
  import scsd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
  localparam int STUCK_LIMIT  = 3000;
  localparam int LONG_HOLD    = 500;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_LEN    = 130;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_item;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int                    report_mismatches;
  int                    reports_due;
  int                    send_idle_pct;
  int                    stall_pct;
  logic                  hold_request;
  logic [31:0]           sample_clock_ms;

  step_counter_sleep_detector u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  step_counter_sleep_detector_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_item           (in_item),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_item          (out_item),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .report_mismatches (report_mismatches),
    .reports_due       (reports_due)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // report side: random stalls, plus one long hold counted here
  initial begin
    int   hold_left;
    logic hold_served;
    hold_left   = 0;
    hold_served = 1'b0;
    out_stall   = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_served) begin
        hold_served = 1'b1;
        hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  initial begin
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // one sample beat, with random idle cycles ahead of it
  task automatic send_beat(input in_item_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= s;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_reading(input int x, input int y, input int z,
                              input logic [31:0] t, input logic roll);
    in_item_t s;
    s.accel_x      = 16'(x);
    s.accel_y      = 16'(y);
    s.accel_z      = 16'(z);
    s.timestamp_ms = t;
    s.day_rollover = roll;
    send_beat(s);
  endtask

  // drop valid and let every report come back before touching registers
  task automatic finish_phase();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (reports_due == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [31:0] mn, input logic [31:0] mx,
                              input logic [31:0] iv, input logic [31:0] sto,
                              input logic [31:0] win, input logic [31:0] wk,
                              input logic [31:0] vl);
    cfg_write(REG_MAGNITUDE_MIN, mn);
    cfg_write(REG_MAGNITUDE_MAX, mx);
    cfg_write(REG_STEP_INTERVAL_MS, iv);
    cfg_write(REG_SLEEP_TIMEOUT_MS, sto);
    cfg_write(REG_ACTIVITY_WINDOW_MS, win);
    cfg_write(REG_WAKE_STEP_COUNT, wk);
    cfg_write(REG_VARIANCE_LIMIT, vl);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // mostly walking motion near the step bounds, some still spells, some noise
  function automatic in_item_t make_sample();
    in_item_t s;
    int       pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      s.accel_x = 16'($urandom);
      s.accel_y = 16'($urandom);
      s.accel_z = 16'($urandom);
    end else if (pick < 25) begin
      s.accel_x = 16'(int'($urandom_range(16)) - 8);
      s.accel_y = 16'(int'($urandom_range(16)) - 8);
      s.accel_z = 16'(4096 + int'($urandom_range(16)) - 8);
    end else begin
      s.accel_x = 16'(int'($urandom_range(6000)) - 3000);
      s.accel_y = 16'(int'($urandom_range(6000)) - 3000);
      s.accel_z = 16'(4096 + int'($urandom_range(8000)) - 2000);
    end
    pick = $urandom_range(99);
    if (pick < 3) sample_clock_ms = $urandom;
    else if (pick < 8) sample_clock_ms += $urandom_range(400000, 2000);
    else sample_clock_ms += $urandom_range(700, 20);
    s.timestamp_ms = sample_clock_ms;
    s.day_rollover = ($urandom_range(99) < 3);
    return s;
  endfunction

  task automatic run_random(input int n, input int send_pct, input int rcv_pct);
    send_idle_pct = send_pct;
    stall_pct     = rcv_pct;
    repeat (n) send_beat(make_sample());
    finish_phase();
  endtask

  initial begin
    in_valid        = 1'b0;
    in_item         = '0;
    cfg_wr_en       = 1'b0;
    cfg_index       = REG_MAGNITUDE_MIN;
    cfg_wdata       = '0;
    rst_n           = 1'b0;
    send_idle_pct   = 0;
    stall_pct       = 0;
    hold_request    = 1'b0;
    sample_clock_ms = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed beats on reset registers
    send_reading(0, 0, 0, 32'd0, 1'b0);
    send_reading(32767, 32767, 32767, 32'd100, 1'b0);
    send_reading(-32768, -32768, -32768, 32'd200, 1'b0);
    send_reading(-32768, 32767, 0, 32'd250, 1'b0);
    // magnitude on the lower bound, then just above it
    send_reading(0, 0, 5325, 32'd1000, 1'b0);
    send_reading(0, 0, 5326, 32'd1400, 1'b0);
    // interval exactly met, then exceeded by one
    send_reading(0, 0, 6000, 32'd1700, 1'b0);
    send_reading(0, 0, 6000, 32'd1701, 1'b0);
    // magnitude on the upper bound, then just below it
    send_reading(0, 0, 12288, 32'd2100, 1'b0);
    send_reading(0, 0, 12287, 32'd2500, 1'b0);
    send_reading(-4000, 3000, -7000, 32'd2600, 1'b0);
    send_reading(0, 0, 4096, 32'd2700, 1'b1);
    // timestamp going backwards
    send_reading(0, 0, 8000, 32'd100, 1'b0);
    // inactivity beyond the sleep timeout
    send_reading(0, 0, 4096, 32'd300101, 1'b0);
    // timestamps across the wrap
    send_reading(0, 0, 8000, 32'hFFFF_FFFF, 1'b0);
    send_reading(0, 0, 8000, 32'h0000_0200, 1'b0);
    send_reading(-1, -1, -1, 32'h0000_0400, 1'b0);
    send_reading(32767, -32768, 4096, 32'h0000_0600, 1'b1);
    sample_clock_ms = 32'h0000_0600;
    finish_phase();

    // reset registers, no idling, with one long report hold
    hold_request = 1'b1;
    run_random(PHASE_LEN, 0, 0);

    // tuned for frequent sleep and wake, sender idling
    program_regs($urandom_range(5000, 3000), $urandom_range(12000, 7000),
                 $urandom_range(400, 0), $urandom_range(20000, 1000),
                 $urandom_range(5000, 500), $urandom_range(6, 1),
                 $urandom_range(300000, 0));
    run_random(PHASE_LEN, 47, 0);

    // widest step band, zero timers, zero wake threshold, receiver stalling
    program_regs(32'd0, 32'hFFFF, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    cfg_write(REG_NONE, 32'h0000_1234);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    run_random(PHASE_LEN, 0, 47);

    // all ones, masked to each register width, both sides idling
    program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_random(PHASE_LEN, 33, 33);

    // random mid settings, any wake threshold
    program_regs($urandom_range(5500, 2000), $urandom_range(14000, 6000),
                 $urandom_range(1000, 0), $urandom_range(600000, 500),
                 $urandom_range(40000, 200), $urandom_range(255, 0),
                 $urandom_range(2000000, 0));
    run_random(PHASE_LEN, 0, 0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (report_mismatches == 0 && reports_due == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
